FILE: hw/rtl/sparse_table_range_min_query_top_defines.svh
// Assertion macros for the sparse table range query block.
`ifndef SPARSE_TABLE_RANGE_MIN_QUERY_TOP_DEFINES_SVH
`define SPARSE_TABLE_RANGE_MIN_QUERY_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define STRMQ_ASSERT_HOLDS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("strmq assertion failed");
`define STRMQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("strmq assertion failed");
`else
`define STRMQ_ASSERT_HOLDS(label, clk, rst_n, prop)
`define STRMQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/strmq_pkg.sv
package strmq_pkg;

	localparam int MAX_ELEMENTS = 1024;
	localparam int NUM_LEVELS   = 11;
	localparam int IDX_W        = 10;
	localparam int CNT_W        = 11;
	localparam int LVL_W        = 4;
	localparam int VALUE_W      = 32;
	localparam int TBL_DEPTH    = NUM_LEVELS * MAX_ELEMENTS;
	localparam int TBL_AW       = LVL_W + IDX_W;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_BUILD  = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_RANGE = 2'd2,
		ST_NOT_BUILT = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t                      command;
		logic signed [VALUE_W-1:0] value;
		logic [IDX_W-1:0]          range_start;
		logic [CNT_W-1:0]          range_end;
	} in_beat_t;

	typedef struct packed {
		status_t                   status;
		logic [IDX_W-1:0]          best_index;
		logic signed [VALUE_W-1:0] best_value;
	} out_beat_t;

endpackage

FILE: hw/rtl/strmq_ram.sv
module strmq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic                     re_b,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re_a) begin
			rdata_a <= mem[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

FILE: hw/rtl/sparse_table_range_min_query_top.sv
// Append, clear, rejected query, empty build: result in the cycle after the beat is taken.
// Query: table read, then element read (one port pair each), then compare.
// Build: S_B_L0 per element, then S_B_RD, S_B_TBL, S_B_WR per entry of levels k >= 1.
// One item in flight; the next beat is taken once the result register is free.
// Reset clears count, built flag, max_mode and control; memories stay undefined.
`include "sparse_table_range_min_query_top_defines.svh"

module sparse_table_range_min_query_top
	import strmq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data,
	input  logic      cfg_we,
	input  logic      cfg_data
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_Q_TBL = 7'b0000010,
		S_Q_ELM = 7'b0000100,
		S_B_L0  = 7'b0001000,
		S_B_RD  = 7'b0010000,
		S_B_TBL = 7'b0100000,
		S_B_WR  = 7'b1000000
	} state_t;

	state_t            state_q, state_nxt;
	logic [CNT_W-1:0]  cnt_q, cnt_nxt;
	logic              built_q, built_nxt;
	logic              max_mode_q;
	logic [LVL_W-1:0]  lvl_q, lvl_nxt;
	logic [CNT_W-1:0]  idx_q, idx_nxt;
	logic              out_valid_q;
	out_beat_t         out_data_q, out_nxt;
	logic              out_load;

	logic              accept;
	logic [CNT_W-1:0]  q_len;
	logic [LVL_W-1:0]  q_lvl;
	logic [CNT_W-1:0]  q_hi;
	logic              q_range_ok;

	logic [LVL_W-1:0]  prev_lvl;
	logic [IDX_W-1:0]  half;
	logic [CNT_W:0]    span;
	logic [CNT_W:0]    nxt_span;
	logic [CNT_W:0]    nxt_end;

	logic              tbl_we, tbl_re;
	logic [TBL_AW-1:0] tbl_waddr, tbl_raddr_a, tbl_raddr_b;
	logic [IDX_W-1:0]  tbl_wdata, tbl_rd_a, tbl_rd_b;
	logic              elm_we, elm_re;
	logic [VALUE_W-1:0] elm_rd_a, elm_rd_b;

	logic                      left_wins;
	logic [IDX_W-1:0]          win_idx;
	logic signed [VALUE_W-1:0] win_val;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign q_len      = in_data.range_end - {1'b0, in_data.range_start};
	assign q_range_ok = ({1'b0, in_data.range_start} < in_data.range_end) &&
		(in_data.range_end <= cnt_q);

	always_comb begin
		q_lvl = '0;
		for (int j = 0; j < CNT_W; j++) begin
			if (q_len[j]) begin
				q_lvl = LVL_W'(j);
			end
		end
	end

	assign q_hi     = in_data.range_end - (CNT_W'(1) << q_lvl);
	assign prev_lvl = lvl_q - LVL_W'(1);
	assign half     = IDX_W'(1) << prev_lvl;
	assign span     = (CNT_W + 1)'(1) << lvl_q;
	assign nxt_span = (CNT_W + 1)'(1) << (lvl_q + LVL_W'(1));
	assign nxt_end  = {1'b0, idx_q} + (CNT_W + 1)'(1) + span;

	assign left_wins = max_mode_q ? ($signed(elm_rd_b) < $signed(elm_rd_a)) :
		($signed(elm_rd_a) < $signed(elm_rd_b));
	assign win_idx   = left_wins ? tbl_rd_a : tbl_rd_b;
	assign win_val   = left_wins ? $signed(elm_rd_a) : $signed(elm_rd_b);

	assign tbl_re      = (accept && in_data.command == CMD_QUERY && q_range_ok && built_q) ||
		(state_q == S_B_RD);
	assign tbl_raddr_a = (state_q == S_IDLE) ? {q_lvl, in_data.range_start} :
		{prev_lvl, idx_q[IDX_W-1:0]};
	assign tbl_raddr_b = (state_q == S_IDLE) ? {q_lvl, q_hi[IDX_W-1:0]} :
		{prev_lvl, idx_q[IDX_W-1:0] + half};
	assign tbl_we      = (state_q == S_B_L0) || (state_q == S_B_WR);
	assign tbl_waddr   = {lvl_q, idx_q[IDX_W-1:0]};
	assign tbl_wdata   = (state_q == S_B_L0) ? idx_q[IDX_W-1:0] : win_idx;

	assign elm_re = (state_q == S_Q_TBL) || (state_q == S_B_TBL);
	assign elm_we = accept && in_data.command == CMD_APPEND && !cnt_q[CNT_W-1];

	strmq_ram #(.WIDTH(IDX_W), .DEPTH(TBL_DEPTH)) u_tbl_ram (
		.clk     (clk),
		.we      (tbl_we),
		.waddr   (tbl_waddr),
		.wdata   (tbl_wdata),
		.re_a    (tbl_re),
		.raddr_a (tbl_raddr_a),
		.rdata_a (tbl_rd_a),
		.re_b    (tbl_re),
		.raddr_b (tbl_raddr_b),
		.rdata_b (tbl_rd_b)
	);

	strmq_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ELEMENTS)) u_elm_ram (
		.clk     (clk),
		.we      (elm_we),
		.waddr   (cnt_q[IDX_W-1:0]),
		.wdata   (in_data.value),
		.re_a    (elm_re),
		.raddr_a (tbl_rd_a),
		.rdata_a (elm_rd_a),
		.re_b    (elm_re),
		.raddr_b (tbl_rd_b),
		.rdata_b (elm_rd_b)
	);

	always_comb begin
		state_nxt = state_q;
		cnt_nxt   = cnt_q;
		built_nxt = built_q;
		lvl_nxt   = lvl_q;
		idx_nxt   = idx_q;
		out_load  = 1'b0;
		out_nxt   = '{status: ST_OK, best_index: '0, best_value: '0};
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (in_data.command)
						CMD_APPEND: begin
							out_load = 1'b1;
							if (cnt_q[CNT_W-1]) begin
								out_nxt.status = ST_FULL;
							end else begin
								cnt_nxt   = cnt_q + CNT_W'(1);
								built_nxt = 1'b0;
							end
						end
						CMD_BUILD: begin
							if (cnt_q == '0) begin
								out_load  = 1'b1;
								built_nxt = 1'b1;
							end else begin
								lvl_nxt   = '0;
								idx_nxt   = '0;
								state_nxt = S_B_L0;
							end
						end
						CMD_QUERY: begin
							if (!q_range_ok) begin
								out_load       = 1'b1;
								out_nxt.status = ST_BAD_RANGE;
							end else if (!built_q) begin
								out_load       = 1'b1;
								out_nxt.status = ST_NOT_BUILT;
							end else begin
								state_nxt = S_Q_TBL;
							end
						end
						CMD_CLEAR: begin
							out_load  = 1'b1;
							cnt_nxt   = '0;
							built_nxt = 1'b0;
						end
						default: begin
							state_nxt = S_IDLE;
						end
					endcase
				end
			end
			S_Q_TBL: begin
				state_nxt = S_Q_ELM;
			end
			S_Q_ELM: begin
				out_load           = 1'b1;
				out_nxt.best_index = win_idx;
				out_nxt.best_value = win_val;
				state_nxt          = S_IDLE;
			end
			S_B_L0: begin
				idx_nxt = idx_q + CNT_W'(1);
				if (idx_q + CNT_W'(1) == cnt_q) begin
					if (cnt_q >= CNT_W'(2)) begin
						lvl_nxt   = LVL_W'(1);
						idx_nxt   = '0;
						state_nxt = S_B_RD;
					end else begin
						out_load  = 1'b1;
						built_nxt = 1'b1;
						state_nxt = S_IDLE;
					end
				end
			end
			S_B_RD: begin
				state_nxt = S_B_TBL;
			end
			S_B_TBL: begin
				state_nxt = S_B_WR;
			end
			S_B_WR: begin
				priority if (nxt_end <= {1'b0, cnt_q}) begin
					idx_nxt   = idx_q + CNT_W'(1);
					state_nxt = S_B_RD;
				end else if (lvl_q < LVL_W'(NUM_LEVELS - 1) &&
						nxt_span <= {1'b0, cnt_q}) begin
					lvl_nxt   = lvl_q + LVL_W'(1);
					idx_nxt   = '0;
					state_nxt = S_B_RD;
				end else begin
					out_load  = 1'b1;
					built_nxt = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
		if (cfg_we) begin
			built_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			built_q     <= 1'b0;
			max_mode_q  <= 1'b0;
			lvl_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= cnt_nxt;
			built_q <= built_nxt;
			lvl_q   <= lvl_nxt;
			idx_q   <= idx_nxt;
			if (cfg_we) begin
				max_mode_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= out_nxt;
		end
	end

	`STRMQ_ASSERT_HOLDS(a_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(MAX_ELEMENTS))
	`STRMQ_ASSERT_IMPL(a_built_on_ok, clk, arst_n, $rose(built_q), out_valid_q && out_data_q.status == ST_OK)
	`STRMQ_ASSERT_IMPL(a_tbl_level, clk, arst_n, tbl_we, lvl_q <= LVL_W'(NUM_LEVELS - 1))

endmodule
